// File: src/dog_ext_pkg.sv
// Shared constants, register indexes and types of the DoG extremum detector.
// No dependencies; every other file of the block imports this package.
package dog_ext_pkg;

   localparam int MAX_LINE_DEF    = 1024;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int ROW_BITS        = 12;
   localparam int TAG_BITS        = 3;
   localparam int CONTRAST_BITS   = 15;
   localparam int RATIO_BITS      = 8;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 16;
   localparam int MIN_LINE        = 3;
   localparam int LINE_LEN_RESET  = 640;
   localparam int CONTRAST_RESET  = 8;
   localparam int RATIO_RESET     = 10;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_LENGTH    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONTRAST_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EDGE_RATIO     = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PROD,
      ST_DET,
      ST_SCALE,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic above_all;
      logic below_all;
   } lane_flags_type;

   typedef struct packed {
      logic prod_en;
      logic det_en;
      logic scale_en;
   } hess_ctrl_type;

endpackage

// File: src/dog_ext_if.sv
// Handshake interfaces of the DoG extremum detector: pixel input, result output, register writes.
// Depends on dog_ext_pkg for field widths.
interface dog_ext_req_if import dog_ext_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] dog_lower;
   logic signed [SAMPLE_BITS-1:0] dog_middle;
   logic signed [SAMPLE_BITS-1:0] dog_upper;
   logic                          frame_start;
   logic [TAG_BITS-1:0]           octave_tag;
   logic [TAG_BITS-1:0]           scale_tag;

   modport source (output valid, dog_lower, dog_middle, dog_upper, frame_start,
                   octave_tag, scale_tag, input ready);
   modport sink (input valid, dog_lower, dog_middle, dog_upper, frame_start,
                 octave_tag, scale_tag, output ready);
endinterface

interface dog_ext_rsp_if import dog_ext_pkg::*; #(
   parameter int MAX_LINE    = MAX_LINE_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   localparam int COL_BITS = $clog2(MAX_LINE);
   logic                          valid;
   logic                          ready;
   logic [COL_BITS-1:0]           center_column;
   logic [ROW_BITS-1:0]           center_row;
   logic                          keypoint_found;
   logic                          is_maximum;
   logic signed [SAMPLE_BITS-1:0] center_value;
   logic [TAG_BITS-1:0]           octave_out;
   logic [TAG_BITS-1:0]           scale_out;

   modport source (output valid, center_column, center_row, keypoint_found, is_maximum,
                   center_value, octave_out, scale_out, input ready);
   modport sink (input valid, center_column, center_row, keypoint_found, is_maximum,
                 center_value, octave_out, scale_out, output ready);
endinterface

interface dog_ext_csr_if import dog_ext_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] reg_index;
   logic [CSR_DATA_BITS-1:0]  wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// File: src/dog_ext_lane.sv
// One comparison lane: tests the center sample against the 3x3 patch of one DoG level.
// Depends on dog_ext_pkg for the flag type.
module dog_ext_lane import dog_ext_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter bit SKIP_CENTER = 1'b0
) (
   input  logic signed [SAMPLE_BITS-1:0] patch [9],
   input  logic signed [SAMPLE_BITS-1:0] center,
   output lane_flags_type                flags
);

   // Patch position 4 is the center itself on the middle level.
   always_comb begin
      flags.above_all = 1'b1;
      flags.below_all = 1'b1;
      for (int i = 0; i < 9; i++) begin
         if (!(SKIP_CENTER && i == 4)) begin
            if (center <= patch[i]) flags.above_all = 1'b0;
            if (center >= patch[i]) flags.below_all = 1'b0;
         end
      end
   end

endmodule

// File: src/dog_ext_hessian.sv
// Hessian edge test over three register stages: products, determinant, ratio scaling.
// Depends on dog_ext_pkg for the stage enable struct.
module dog_ext_hessian import dog_ext_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  hess_ctrl_type                    ctrl,
   input  logic signed [SAMPLE_BITS+1:0]    dxx,
   input  logic signed [SAMPLE_BITS+1:0]    dyy,
   input  logic signed [SAMPLE_BITS+1:0]    dxy4,
   input  logic [RATIO_BITS-1:0]            edge_ratio,
   output logic                             edge_ok
);

   localparam int D   = SAMPLE_BITS + 2;
   localparam int PW  = 2 * D;
   localparam int DW  = 2 * D + 5;
   localparam int TW  = 2 * D + 2;
   localparam int LO  = DW / 2;
   localparam int R16 = RATIO_BITS + 4;
   localparam int RRW = 2 * (RATIO_BITS + 1);
   localparam int CW  = DW + RRW + 1;

   logic signed [PW-1:0]      pxy_ff, pdd_ff;
   logic signed [D:0]         tr_ff;
   logic [R16-1:0]            r16_ff;
   logic [RRW-1:0]            rr1_ff;
   logic signed [DW-1:0]      det_ff;
   logic signed [TW-1:0]      tr2_ff;
   logic [TW+R16-1:0]         lhs_ff;
   logic [LO+RRW-1:0]         rhs_lo_ff;
   logic [DW-LO+RRW-1:0]      rhs_hi_ff;
   logic                      det_pos_ff;
   logic [CW-1:0]             rhs_sum;

   always_ff @(posedge clock) begin
      if (ctrl.prod_en) begin
         pxy_ff <= dxx * dyy;
         pdd_ff <= dxy4 * dxy4;
         tr_ff  <= (D+1)'(dxx) + (D+1)'(dyy);
         r16_ff <= {edge_ratio, 4'b0000};
         rr1_ff <= (RATIO_BITS+1)'(edge_ratio) + 1'b1;
      end
      if (ctrl.det_en) begin
         det_ff <= (DW'(pxy_ff) <<< 4) - DW'(pdd_ff);
         tr2_ff <= tr_ff * tr_ff;
         rr1_ff <= rr1_ff[RATIO_BITS:0] * rr1_ff[RATIO_BITS:0];
      end
      if (ctrl.scale_en) begin
         lhs_ff     <= $unsigned(tr2_ff) * r16_ff;
         rhs_lo_ff  <= det_ff[LO-1:0] * rr1_ff;
         rhs_hi_ff  <= det_ff[DW-1:LO] * rr1_ff;
         det_pos_ff <= (det_ff > 0);
      end
   end

   // Both sides are exact, so a single unsigned compare decides the ratio test.
   assign rhs_sum = (CW'(rhs_hi_ff) << LO) + CW'(rhs_lo_ff);
   assign edge_ok = det_pos_ff && (CW'(lhs_ff) < rhs_sum);

endmodule

// File: src/dog_extremum_keypoint_detect_core.sv
// Top level of the DoG extremum keypoint detector: line stores, window, lanes, merge, output.
// Depends on dog_ext_pkg, dog_ext_if, dog_ext_lane and dog_ext_hessian.
//
//   channel   direction  handshake         contents
//   req_bus   in         valid / ready     three DoG samples, frame_start, octave and scale tags
//   rsp_bus   out        valid / ready     center position, keypoint flags, center value, tags
//   csr_bus   in         valid / ready     register index and write data (always ready)
//
// Each pixel transaction steps in order through ST_IDLE, which reads the two line stores,
// ST_LOAD for the three comparison lanes and their merge, ST_PROD, ST_DET and ST_SCALE for
// the three Hessian multiplier stages, and ST_DONE for the hand-over to the output register.
// Reset is synchronous and clears the counters, the window and the registers to defaults.
// A result that is not taken holds the block in its last step until rsp_bus.ready comes.
module dog_extremum_keypoint_detect_core import dog_ext_pkg::*; #(
   parameter int MAX_LINE    = MAX_LINE_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   dog_ext_req_if.sink       req_bus,
   dog_ext_rsp_if.source     rsp_bus,
   dog_ext_csr_if.sink       csr_bus
);

   localparam int COL_BITS = $clog2(MAX_LINE);
   localparam int LEN_BITS = $clog2(MAX_LINE + 1);
   localparam int S        = SAMPLE_BITS;
   localparam int D        = S + 2;
   localparam int LW       = 3 * S;

   // Configuration registers.
   logic [LEN_BITS-1:0]      line_len_ff;
   logic [CONTRAST_BITS-1:0] contrast_ff;
   logic [RATIO_BITS-1:0]    ratio_ff;
   logic [LEN_BITS-1:0]      eff_len;

   // Sequencer.
   seq_state_type state_ff, state_in;
   logic          accept, load_en, out_load;
   hess_ctrl_type hess_ctrl;

   // Position counters and the item at work.
   logic [COL_BITS-1:0] col_ff, col_in, start_col, item_col_ff;
   logic [ROW_BITS-1:0] row_ff, row_in, start_row, item_row_ff;
   logic [LEN_BITS-1:0] col_p1;
   logic [LW-1:0]       cur_ff;
   logic [TAG_BITS-1:0] octave_ff, scale_ff;

   // Line stores, one entry per column with all three levels side by side.
   logic [LW-1:0] mem_older [MAX_LINE];
   logic [LW-1:0] mem_newer [MAX_LINE];
   logic [LW-1:0] rd_older_ff, rd_newer_ff;

   // Window: level, row (top, middle, bottom), column (two left of the incoming one).
   logic signed [S-1:0] win_ff [3][3][2];
   logic signed [S-1:0] nb [3][3][3];
   logic signed [S-1:0] lane_patch [3][9];
   logic signed [S-1:0] center;
   lane_flags_type      lane_flags [3];

   // Merge results and Hessian inputs.
   logic                is_max, is_min, contrast_ok;
   logic [S-1:0]        mag;
   logic                is_max_ff, ext_ok_ff, emit_ff, edge_ok;
   logic signed [S-1:0] value_ff;
   logic signed [D-1:0] dxx_ff, dyy_ff, dxy4_ff;

   // Output register.
   logic                rsp_valid_ff;
   logic [COL_BITS-1:0] out_col_ff;
   logic [ROW_BITS-1:0] out_row_ff;
   logic                out_found_ff, out_max_ff;
   logic signed [S-1:0] out_value_ff;
   logic [TAG_BITS-1:0] out_octave_ff, out_scale_ff;

   // ---------------------------------------------------------------- configuration
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_len_ff <= LEN_BITS'(LINE_LEN_RESET);
         contrast_ff <= CONTRAST_BITS'(CONTRAST_RESET);
         ratio_ff    <= RATIO_BITS'(RATIO_RESET);
      end else if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            CSR_LINE_LENGTH:    line_len_ff <= csr_bus.wr_data[LEN_BITS-1:0];
            CSR_CONTRAST_LIMIT: contrast_ff <= csr_bus.wr_data[CONTRAST_BITS-1:0];
            CSR_EDGE_RATIO:     ratio_ff    <= csr_bus.wr_data[RATIO_BITS-1:0];
            default: ;
         endcase
      end
   end

   // The line length in use is clamped to at least MIN_LINE and to what the line stores can hold.
   always_comb begin
      if (line_len_ff < LEN_BITS'(MIN_LINE)) begin
         eff_len = LEN_BITS'(MIN_LINE);
      end else if (line_len_ff > LEN_BITS'(MAX_LINE)) begin
         eff_len = LEN_BITS'(MAX_LINE);
      end else begin
         eff_len = line_len_ff;
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_bus.valid) state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_PROD;
         ST_PROD:  state_in = ST_DET;
         ST_DET:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_DONE;
         ST_DONE:  if (!emit_ff || !rsp_valid_ff || rsp_bus.ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready      = (state_ff == ST_IDLE);
      load_en            = (state_ff == ST_LOAD);
      hess_ctrl.prod_en  = (state_ff == ST_PROD);
      hess_ctrl.det_en   = (state_ff == ST_DET);
      hess_ctrl.scale_en = (state_ff == ST_SCALE);
      out_load           = (state_ff == ST_DONE) && emit_ff &&
                           (!rsp_valid_ff || rsp_bus.ready);
   end

   assign accept = req_bus.valid && req_bus.ready;

   // ---------------------------------------------------------------- position counters
   // A frame start restarts at the origin; a column count left beyond a shortened line
   // wraps to the next row before the pixel is placed.
   always_comb begin
      if (req_bus.frame_start) begin
         start_col = '0;
         start_row = '0;
      end else if (LEN_BITS'(col_ff) >= eff_len) begin
         start_col = '0;
         start_row = row_ff + 1'b1;
      end else begin
         start_col = col_ff;
         start_row = row_ff;
      end
      col_p1 = LEN_BITS'(start_col) + 1'b1;
      if (col_p1 >= eff_len) begin
         col_in = '0;
         row_in = start_row + 1'b1;
      end else begin
         col_in = col_p1[COL_BITS-1:0];
         row_in = start_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_col_ff <= start_col;
         item_row_ff <= start_row;
         cur_ff      <= {req_bus.dog_upper, req_bus.dog_middle, req_bus.dog_lower};
         octave_ff   <= req_bus.octave_tag;
         scale_ff    <= req_bus.scale_tag;
      end
   end

   // ---------------------------------------------------------------- line stores
   // Read when the transaction is taken; the column moves down one store in the next cycle, in ST_LOAD.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_older_ff <= mem_older[start_col];
         rd_newer_ff <= mem_newer[start_col];
      end
      if (load_en) begin
         mem_older[item_col_ff] <= rd_newer_ff;
         mem_newer[item_col_ff] <= cur_ff;
      end
   end

   // ---------------------------------------------------------------- neighborhood
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         for (int r = 0; r < 3; r++) begin
            nb[l][r][0] = win_ff[l][r][0];
            nb[l][r][1] = win_ff[l][r][1];
         end
         nb[l][0][2] = rd_older_ff[l*S +: S];
         nb[l][1][2] = rd_newer_ff[l*S +: S];
         nb[l][2][2] = cur_ff[l*S +: S];
         for (int i = 0; i < 9; i++) begin
            lane_patch[l][i] = nb[l][i / 3][i % 3];
         end
      end
   end

   assign center = nb[1][1][1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < 3; l++) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[l][r][0] <= '0;
               win_ff[l][r][1] <= '0;
            end
         end
      end else if (load_en) begin
         for (int l = 0; l < 3; l++) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[l][r][0] <= nb[l][r][1];
               win_ff[l][r][1] <= nb[l][r][2];
            end
         end
      end
   end

   // ---------------------------------------------------------------- comparison lanes
   // Lane 1 is the level under test and leaves out the center itself.
   for (genvar g = 0; g < 3; g++) begin : g_lane
      dog_ext_lane #(
         .SAMPLE_BITS (S),
         .SKIP_CENTER (g == 1)
      ) u_lane (
         .patch  (lane_patch[g]),
         .center (center),
         .flags  (lane_flags[g])
      );
   end

   // Merge: a strict extremum must hold on every lane.
   always_comb begin
      is_max      = lane_flags[0].above_all && lane_flags[1].above_all &&
                    lane_flags[2].above_all;
      is_min      = lane_flags[0].below_all && lane_flags[1].below_all &&
                    lane_flags[2].below_all;
      mag         = center[S-1] ? S'(-center) : S'(center);
      contrast_ok = (S+CONTRAST_BITS)'(mag) >= (S+CONTRAST_BITS)'(contrast_ff);
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         is_max_ff <= is_max;
         ext_ok_ff <= (is_max || is_min) && contrast_ok;
         emit_ff   <= (item_col_ff >= COL_BITS'(2)) && (item_row_ff >= ROW_BITS'(2));
         value_ff  <= center;
         dxx_ff    <= D'(nb[1][1][2]) + D'(nb[1][1][0]) - (D'(center) <<< 1);
         dyy_ff    <= D'(nb[1][2][1]) + D'(nb[1][0][1]) - (D'(center) <<< 1);
         dxy4_ff   <= D'(nb[1][2][2]) - D'(nb[1][2][0]) - D'(nb[1][0][2]) + D'(nb[1][0][0]);
      end
   end

   // ---------------------------------------------------------------- edge test
   dog_ext_hessian #(
      .SAMPLE_BITS (S)
   ) u_hessian (
      .clock      (clock),
      .ctrl       (hess_ctrl),
      .dxx        (dxx_ff),
      .dyy        (dyy_ff),
      .dxy4       (dxy4_ff),
      .edge_ratio (ratio_ff),
      .edge_ok    (edge_ok)
   );

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_col_ff    <= item_col_ff - 1'b1;
         out_row_ff    <= item_row_ff - 1'b1;
         out_found_ff  <= ext_ok_ff && edge_ok;
         out_max_ff    <= is_max_ff;
         out_value_ff  <= value_ff;
         out_octave_ff <= octave_ff;
         out_scale_ff  <= scale_ff;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.center_column  = out_col_ff;
   assign rsp_bus.center_row     = out_row_ff;
   assign rsp_bus.keypoint_found = out_found_ff;
   assign rsp_bus.is_maximum     = out_max_ff;
   assign rsp_bus.center_value   = out_value_ff;
   assign rsp_bus.octave_out     = out_octave_ff;
   assign rsp_bus.scale_out      = out_scale_ff;

endmodule

// File: src/dog_ext_checker.sv
// Port-level assertions for the DoG extremum detector and the bind that attaches them.
// Depends on dog_ext_pkg and on the top level dog_extremum_keypoint_detect_core.
module dog_ext_port_props import dog_ext_pkg::*; #(
   parameter int MAX_LINE    = MAX_LINE_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [$clog2(MAX_LINE)-1:0]   center_column,
   input logic [ROW_BITS-1:0]           center_row,
   input logic                          is_maximum,
   input logic signed [SAMPLE_BITS-1:0] center_value
);

   localparam logic [SAMPLE_BITS-1:0] MOST_NEGATIVE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction dropped before it was taken");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second pixel transaction taken while one is at work");

   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (center_column != '0) && (center_row != '0))
      else $error("result reported for a border pixel");

   a_max_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_maximum |-> center_value != MOST_NEGATIVE)
      else $error("most negative sample reported as a strict maximum");

endmodule

bind dog_extremum_keypoint_detect_core dog_ext_port_props #(
   .MAX_LINE    (MAX_LINE),
   .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .center_column (rsp_bus.center_column),
   .center_row    (rsp_bus.center_row),
   .is_maximum    (rsp_bus.is_maximum),
   .center_value  (rsp_bus.center_value)
);

// File: test/dog_ext_checker.sv
// Passive checker of the DoG extremum detector: tracks register writes, predicts each result
// from the pixel stream and compares it with the result channel. Depends on dog_ext_pkg, dog_ext_if.
module dog_ext_checker import dog_ext_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   dog_ext_req_if  req,
   dog_ext_rsp_if  rsp,
   dog_ext_csr_if  csr,
   output int      fail_count,
   output int      pending,
   output int      results_seen,
   output int      keypoints_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [9:0]         column;
      logic [ROW_BITS-1:0] row;
      logic               found;
      logic               maximum;
      logic signed [15:0] value;
      logic [2:0]         octave;
      logic [2:0]         scale;
   } center_result_type;

   center_result_type expected_centers[$];

   int line_len, contrast, ratio;
   int older_row[MAX_LINE_DEF][3];
   int newer_row[MAX_LINE_DEF][3];
   int win[3][3][2];
   int col_pos, row_pos;

   assign pending = expected_centers.size();

   task automatic predict_center(input int lower, input int middle, input int upper,
                                 input logic fs, input logic [2:0] oct, input logic [2:0] scl);
      int eff, cur[3], nb[3][3][3], v, mag;
      bit is_max, is_min, found;
      longint dxx, dyy, dxy4, det16, tr;
      logic [127:0] lhs, rhs;
      center_result_type res;
      eff = line_len < MIN_LINE ? MIN_LINE : (line_len > MAX_LINE_DEF ? MAX_LINE_DEF : line_len);
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end else if (col_pos >= eff) begin
         col_pos = 0;
         row_pos = (row_pos + 1) & 12'hFFF;
      end
      cur[0] = lower;
      cur[1] = middle;
      cur[2] = upper;
      for (int l = 0; l < 3; l++) begin
         nb[l][0][2] = older_row[col_pos][l];
         nb[l][1][2] = newer_row[col_pos][l];
         nb[l][2][2] = cur[l];
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 2; c++)
               nb[l][r][c] = win[l][r][c];
      end
      if (col_pos >= 2 && row_pos >= 2) begin
         v = nb[1][1][1];
         mag = v < 0 ? -v : v;
         is_max = 1;
         is_min = 1;
         for (int l = 0; l < 3; l++)
            for (int r = 0; r < 3; r++)
               for (int c = 0; c < 3; c++) begin
                  if (!(l == 1 && r == 1 && c == 1)) begin
                     if (v <= nb[l][r][c]) is_max = 0;
                     if (v >= nb[l][r][c]) is_min = 0;
                  end
               end
         found = (is_max || is_min) && mag >= contrast;
         if (found) begin
            dxx = longint'(nb[1][1][2]) + nb[1][1][0] - 2 * longint'(v);
            dyy = longint'(nb[1][2][1]) + nb[1][0][1] - 2 * longint'(v);
            dxy4 = longint'(nb[1][2][2]) - nb[1][2][0] - nb[1][0][2] + nb[1][0][0];
            det16 = 16 * dxx * dyy - dxy4 * dxy4;
            tr = dxx + dyy;
            if (det16 <= 0) begin
               found = 0;
            end else begin
               lhs = 128'(tr * tr) * 128'(16 * ratio);
               rhs = 128'(det16) * 128'((ratio + 1) * (ratio + 1));
               found = lhs < rhs;
            end
         end
         res.column = 10'(col_pos - 1);
         res.row = 12'(row_pos - 1);
         res.found = found;
         res.maximum = is_max;
         res.value = 16'(v);
         res.octave = oct;
         res.scale = scl;
         expected_centers.push_back(res);
      end
      for (int l = 0; l < 3; l++) begin
         for (int r = 0; r < 3; r++) begin
            win[l][r][0] = nb[l][r][1];
            win[l][r][1] = nb[l][r][2];
         end
         older_row[col_pos][l] = newer_row[col_pos][l];
         newer_row[col_pos][l] = cur[l];
      end
      col_pos++;
      if (col_pos >= eff) begin
         col_pos = 0;
         row_pos = (row_pos + 1) & 12'hFFF;
      end
   endtask

   task automatic compare_field(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         fail_count++;
         $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   initial begin
      fail_count = 0;
      results_seen = 0;
      keypoints_seen = 0;
   end

   always @(posedge clock) begin
      center_result_type exp_r;
      if (reset) begin
         line_len = LINE_LEN_RESET;
         contrast = CONTRAST_RESET;
         ratio = RATIO_RESET;
         for (int i = 0; i < MAX_LINE_DEF; i++)
            for (int l = 0; l < 3; l++) begin
               older_row[i][l] = 0;
               newer_row[i][l] = 0;
            end
         for (int l = 0; l < 3; l++)
            for (int r = 0; r < 3; r++)
               for (int c = 0; c < 2; c++)
                  win[l][r][c] = 0;
         col_pos = 0;
         row_pos = 0;
         expected_centers.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.reg_index)
               CSR_LINE_LENGTH:    line_len = csr.wr_data[10:0];
               CSR_CONTRAST_LIMIT: contrast = csr.wr_data[CONTRAST_BITS-1:0];
               CSR_EDGE_RATIO:     ratio = csr.wr_data[RATIO_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            results_seen++;
            if (expected_centers.size() == 0) begin
               fail_count++;
               $display("%0t: result with no expectation, actual column %0d row %0d",
                        $time, rsp.center_column, rsp.center_row);
            end else begin
               exp_r = expected_centers.pop_front();
               if (exp_r.found) keypoints_seen++;
               compare_field("center_column", exp_r.column, rsp.center_column);
               compare_field("center_row", exp_r.row, rsp.center_row);
               compare_field("keypoint_found", exp_r.found, rsp.keypoint_found);
               compare_field("is_maximum", exp_r.maximum, rsp.is_maximum);
               compare_field("center_value", exp_r.value, rsp.center_value);
               compare_field("octave_out", exp_r.octave, rsp.octave_out);
               compare_field("scale_out", exp_r.scale, rsp.scale_out);
            end
         end
         if (req.valid && req.ready)
            predict_center(req.dog_lower, req.dog_middle, req.dog_upper, req.frame_start,
                           req.octave_tag, req.scale_tag);
      end
   end
endmodule

// File: test/tb_dog_extremum_keypoint_detect_core.sv
// Testbench top of the DoG extremum detector: clock, reset, stimulus, stalls and verdict.
// Depends on dog_ext_pkg, dog_ext_if, the core and dog_ext_checker.
module tb_dog_extremum_keypoint_detect_core import dog_ext_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;

   dog_ext_req_if req_bus();
   dog_ext_rsp_if rsp_bus();
   dog_ext_csr_if csr_bus();

   int fail_count, pending, results_seen, keypoints_seen;
   int pixels_sent;
   bit no_idle;          // When set, neither side inserts gaps or stalls.
   bit rsp_taken;        // A result transaction completed at the last rising edge.
   int stall_left;

   dog_extremum_keypoint_detect_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   dog_ext_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_bus),
      .rsp            (rsp_bus),
      .csr            (csr_bus),
      .fail_count     (fail_count),
      .pending        (pending),
      .results_seen   (results_seen),
      .keypoints_seen (keypoints_seen)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The receiver draws a fresh stall after every completed result transaction.
   always @(posedge clock) begin
      rsp_taken = rsp_bus.valid && rsp_bus.ready;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready = 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_taken) begin
            stall_left = no_idle ? 0 : $urandom_range(0, 11);
            rsp_taken = 0;
         end
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // Hands one pixel transaction to the block. It is called at a falling edge and
   // returns at the falling edge after acceptance; valid stays high when the next
   // pixel follows without a gap.
   task automatic send_pixel(input logic signed [15:0] lower, input logic signed [15:0] middle,
                             input logic signed [15:0] upper, input logic fs,
                             input logic [2:0] oct, input logic [2:0] scl);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.dog_lower = lower;
      req_bus.dog_middle = middle;
      req_bus.dog_upper = upper;
      req_bus.frame_start = fs;
      req_bus.octave_tag = oct;
      req_bus.scale_tag = scl;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      pixels_sent++;
   endtask

   // Waits for all expected results, then lets the pipeline drain border pixels.
   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      csr_bus.valid = 1'b1;
      csr_bus.reg_index = index;
      csr_bus.wr_data = data;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic configure(input int len, input int lim, input int r);
      wait_drained();
      write_register(CSR_LINE_LENGTH, 16'(len));
      write_register(CSR_CONTRAST_LIMIT, 16'(lim));
      write_register(CSR_EDGE_RATIO, 16'(r));
   endtask

   // A 3x3 frame whose middle pixel is center and all other samples are ring.
   task automatic directed_frame(input logic signed [15:0] ring, input logic signed [15:0] center,
                                 input logic [2:0] oct, input logic [2:0] scl);
      for (int i = 0; i < 9; i++)
         send_pixel(ring, (i == 4) ? center : ring, ring, i == 0, oct, scl);
   endtask

   // Random frames on the current line length. Most pixels are a low noise floor with
   // occasional spikes on the middle level so that true extrema appear; a tenth are
   // full-range values, and now and then a frame restarts early.
   task automatic random_pixels(input int count, input int len, input bit hold_midway);
      int idx, eff;
      logic [2:0] oct, scl;
      logic signed [15:0] lo, mi, up;
      bit fs;
      eff = len < MIN_LINE ? MIN_LINE : (len > MAX_LINE_DEF ? MAX_LINE_DEF : len);
      idx = 0;
      oct = 3'($urandom_range(0, 7));
      scl = 3'($urandom_range(0, 7));
      for (int n = 0; n < count; n++) begin
         fs = (idx == 0) || ($urandom_range(0, 299) == 0);
         if (fs) idx = 0;
         if ($urandom_range(0, 9) == 0) begin
            lo = 16'($urandom);
            mi = 16'($urandom);
            up = 16'($urandom);
         end else begin
            lo = 16'($signed($urandom_range(0, 127)) - 64);
            mi = 16'($signed($urandom_range(0, 127)) - 64);
            up = 16'($signed($urandom_range(0, 127)) - 64);
            if ($urandom_range(0, 5) == 0) begin
               mi = 16'($urandom_range(1000, 32767));
               if ($urandom_range(0, 1)) mi = 16'(-mi - $urandom_range(0, 1));
            end
         end
         if ($urandom_range(0, 19) == 0) begin
            oct = 3'($urandom_range(0, 7));
            scl = 3'($urandom_range(0, 7));
         end
         send_pixel(lo, mi, up, fs, oct, scl);
         idx++;
         if (idx >= eff * 40) idx = 0;
         if (hold_midway && n == count / 2) wait_drained();
      end
   endtask

   initial begin
      reset = 1'b1;
      no_idle = 0;
      pixels_sent = 0;
      rsp_taken = 0;
      req_bus.valid = 1'b0;
      req_bus.dog_lower = '0;
      req_bus.dog_middle = '0;
      req_bus.dog_upper = '0;
      req_bus.frame_start = 1'b0;
      req_bus.octave_tag = '0;
      req_bus.scale_tag = '0;
      csr_bus.valid = 1'b0;
      csr_bus.reg_index = CSR_LINE_LENGTH;
      csr_bus.wr_data = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed: a line length below the minimum clamps to three pixels, so every
      // frame has exactly one interior center. Strongest maximum, strongest minimum,
      // and a flat frame that is neither.
      configure(0, 0, 1);
      directed_frame(-16'sd32768, 16'sd32767, 3'd7, 3'd0);
      directed_frame(16'sd32767, -16'sd32768, 3'd0, 3'd7);
      directed_frame(16'sd5, 16'sd5, 3'd5, 3'd2);

      // Random phases sweep the registers, extremes included. Edge ratio zero
      // reduces the edge test to a positive determinant.
      configure(5, 8, 10);
      random_pixels(110, 5, 0);
      configure(3, 32767, 255);
      random_pixels(90, 3, 0);
      no_idle = 1;
      configure(16, 0, 1);
      random_pixels(130, 16, 0);
      no_idle = 0;
      configure(7, 100, 0);
      random_pixels(120, 7, 1);
      configure(2047, 20, 4);
      random_pixels(40, 2047, 0);
      configure(9, 2000, 30);
      random_pixels(90, 9, 0);
      configure(1024, 1, 255);
      random_pixels(40, 1024, 0);
      configure(4, 65535, 65535);
      random_pixels(110, 4, 0);

      wait_drained();
      $display("Sent %0d pixels over nine register settings; checked %0d centers, %0d keypoints.",
               pixels_sent, results_seen, keypoints_seen);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d results still expected.", pending);
      $display("Regression FAIL");
      $finish;
   end
endmodule

// File: dog_extremum_keypoint_detect_core.f
src/dog_ext_pkg.sv
src/dog_ext_if.sv
src/dog_ext_lane.sv
src/dog_ext_hessian.sv
src/dog_extremum_keypoint_detect_core.sv
src/dog_ext_checker.sv
test/dog_ext_checker.sv
test/tb_dog_extremum_keypoint_detect_core.sv
